/* hdl/hoc_pkg.sv */
// ----------------------------------------------------------------------------
// hoc_pkg
// Shared types and constants of the hashed occurrence counter: opcodes,
// sequencer states, hash constants and the hash unit control group.
// ----------------------------------------------------------------------------
package hoc_pkg;

	localparam logic OP_CLEAR = 1'b0;
	localparam logic OP_COUNT = 1'b1;

	localparam int  LEN_W   = 3;
	localparam int  SCOPE_W = 16;
	localparam int  COUNT_W = 16;
	localparam int  HASH_W  = 64;

	localparam logic [HASH_W-1:0]  HASH_BASIS = 64'd14695981039346656037;
	// prime 1099511628211 = 2^40 + 435
	localparam logic [8:0]         PRIME_LO    = 9'd435;
	localparam int                 PRIME_SHIFT = 40;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_HASH,
		ST_LOOKUP,
		ST_PROBE,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic               init;
		logic               step;
		logic [SCOPE_W-1:0] operand;
	} hash_ctrl_t;

endpackage

/* hdl/hoc_hash.sv */
// ----------------------------------------------------------------------------
// hoc_hash
// Shared FNV-1a 64 step unit: one xor and one multiply by the prime per
// cycle while step is high, the multiply done as a shift and a narrow product.
// ----------------------------------------------------------------------------
module hoc_hash (
	input  logic                        clk,
	input  hoc_pkg::hash_ctrl_t         ctrl,
	output logic [hoc_pkg::HASH_W-1:0]  hash
);
	import hoc_pkg::*;

	logic [HASH_W-1:0] h_q;
	logic [HASH_W-1:0] mixed;
	logic [HASH_W-1:0] product;

	assign mixed   = h_q ^ HASH_W'(ctrl.operand);
	assign product = HASH_W'(mixed * PRIME_LO) + (mixed << PRIME_SHIFT);

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			h_q <= HASH_BASIS;
		end else if (ctrl.step) begin
			h_q <= product;
		end
	end

	assign hash = h_q;

endmodule

/* hdl/hoc_slot_ram.sv */
// ----------------------------------------------------------------------------
// hoc_slot_ram
// Slot table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hoc_slot_ram #(
	parameter int DEPTH  = 256,
	parameter int DATA_W = 68
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hdl/hashed_occurrence_counter.sv */
// ----------------------------------------------------------------------------
// hashed_occurrence_counter
// Counts occurrences of (key, scope) pairs in a linear-probing hash table
// indexed by an FNV-1a 64 hash, with a table clear operation.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A count item steps the
// shared hash step unit once per key byte and once for the scope, makes the
// first table read and then probes one slot a cycle until it finds a free
// slot or a match, or has probed every slot. A clear item sweeps the table
// one slot a cycle. After reset the same sweep runs with busy high. Each
// item gives exactly one result, on done for a single cycle right after the
// item's last busy cycle; the receiver cannot stall it and must take it then.
// ----------------------------------------------------------------------------
module hashed_occurrence_counter #(
	parameter int TABLE_SLOTS = 256,
	parameter int KEY_BYTES   = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         opcode,
	input  logic [31:0]                  key_bytes,
	input  logic [hoc_pkg::LEN_W-1:0]    key_length,
	input  logic [hoc_pkg::SCOPE_W-1:0]  scope,
	output logic                         done,
	output logic [hoc_pkg::COUNT_W-1:0]  occurrence_count,
	output logic                         status
);
	import hoc_pkg::*;

	localparam int IDX_W     = $clog2(TABLE_SLOTS);
	localparam int LEN_LIMIT = (KEY_BYTES < 4) ? KEY_BYTES : 4;
	localparam int KEY_W     = 8 * LEN_LIMIT;
	localparam int LEN_LO    = KEY_W;
	localparam int SCOPE_LO  = LEN_LO + LEN_W;
	localparam int COUNT_LO  = SCOPE_LO + SCOPE_W;
	localparam int USED_BIT  = COUNT_LO + COUNT_W;
	localparam int ENTRY_W   = USED_BIT + 1;

	state_t state_q, state_d;

	logic [KEY_W-1:0]   key_q;
	logic [LEN_W-1:0]   len_q;
	logic [SCOPE_W-1:0] scope_q;
	logic [LEN_W-1:0]   byte_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   probe_q;
	logic [IDX_W-1:0]   clr_q;
	logic               done_q;
	logic [COUNT_W-1:0] count_q;
	logic               status_q;

	logic [LEN_W-1:0]   len_in;
	logic [KEY_W-1:0]   key_in;
	logic [31:0]        key_wide;
	logic [7:0]         cur_byte;
	logic               accept;

	hash_ctrl_t         hctl;
	logic [HASH_W-1:0]  hash;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [IDX_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	logic               rd_used;
	logic [KEY_W-1:0]   rd_key;
	logic [LEN_W-1:0]   rd_len;
	logic [SCOPE_W-1:0] rd_scope;
	logic [COUNT_W-1:0] rd_count;
	logic               hit;
	logic [COUNT_W-1:0] count_inc;

	logic               res_valid;
	logic [COUNT_W-1:0] res_count;
	logic               res_status;

	hoc_hash u_hash (
		.clk  (clk),
		.ctrl (hctl),
		.hash (hash)
	);

	hoc_slot_ram #(
		.DEPTH  (TABLE_SLOTS),
		.DATA_W (ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	assign len_in = (key_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : key_length;

	always_comb begin
		for (int b = 0; b < LEN_LIMIT; b++) begin
			key_in[8*b +: 8] = (LEN_W'(b) < len_in) ? key_bytes[8*b +: 8] : 8'h00;
		end
	end

	assign key_wide = 32'(key_q);
	assign cur_byte = key_wide[{byte_q[1:0], 3'b000} +: 8];

	assign rd_used   = ram_rdata[USED_BIT];
	assign rd_key    = ram_rdata[KEY_W-1:0];
	assign rd_len    = ram_rdata[LEN_LO +: LEN_W];
	assign rd_scope  = ram_rdata[SCOPE_LO +: SCOPE_W];
	assign rd_count  = ram_rdata[COUNT_LO +: COUNT_W];
	assign hit       = rd_used && (rd_key == key_q) && (rd_len == len_q) &&
	                   (rd_scope == scope_q);
	assign count_inc = (rd_count == COUNT_MAX) ? rd_count : rd_count + 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (clr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = (opcode == OP_CLEAR) ? ST_CLEAR : ST_HASH;
			end
			ST_HASH: begin
				if (byte_q == len_q) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				state_d = ST_PROBE;
			end
			ST_PROBE: begin
				if (!rd_used || hit || probe_q == '1) state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				if (clr_q == '1) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	// outputs
	always_comb begin
		hctl       = '0;
		ram_we     = 1'b0;
		ram_waddr  = idx_q;
		ram_wdata  = '0;
		ram_raddr  = idx_q;
		res_valid  = 1'b0;
		res_count  = '0;
		res_status = 1'b0;
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_IDLE: begin
				hctl.init = accept && (opcode == OP_COUNT);
			end
			ST_HASH: begin
				hctl.step    = 1'b1;
				hctl.operand = (byte_q < len_q) ? SCOPE_W'(cur_byte) : scope_q;
			end
			ST_LOOKUP: begin
				ram_raddr = hash[IDX_W-1:0];
			end
			ST_PROBE: begin
				ram_raddr = idx_q + 1'b1;
				if (!rd_used) begin
					ram_we    = 1'b1;
					ram_wdata = {1'b1, COUNT_W'(1), scope_q, len_q, key_q};
					res_valid = 1'b1;
					res_count = COUNT_W'(1);
				end else if (hit) begin
					ram_we    = 1'b1;
					ram_wdata = {1'b1, count_inc, scope_q, len_q, key_q};
					res_valid = 1'b1;
					res_count = count_inc;
				end else if (probe_q == '1) begin
					res_valid  = 1'b1;
					res_status = 1'b1;
				end
			end
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				res_valid = (clr_q == '1);
			end
			default: begin
				hctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_valid;
			if (state_q == ST_INIT || state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end else begin
				clr_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		count_q  <= res_count;
		status_q <= res_status;
		if (accept) begin
			key_q   <= key_in;
			len_q   <= len_in;
			scope_q <= scope;
			byte_q  <= '0;
		end else if (state_q == ST_HASH) begin
			byte_q <= byte_q + 1'b1;
		end
		if (state_q == ST_LOOKUP) begin
			idx_q   <= hash[IDX_W-1:0];
			probe_q <= '0;
		end else if (state_q == ST_PROBE) begin
			idx_q   <= idx_q + 1'b1;
			probe_q <= probe_q + 1'b1;
		end
	end

	assign done             = done_q;
	assign occurrence_count = count_q;
	assign status           = status_q;

endmodule

/* bench/hashed_occurrence_counter_test.sv */
// ----------------------------------------------------------------------------
// hashed_occurrence_counter_test
// Self-checking bench for the hashed occurrence counter. A tally object keeps
// its own FNV-1a 64 hash table, predicts the count and status of every item
// and checks each done strobe against the oldest pending prediction. Stimulus
// covers key length and byte corner cases, clears, probing chains and a full
// table, with bursty start pacing.
// ----------------------------------------------------------------------------
module hashed_occurrence_counter_test;

	timeunit 1ns;
	timeprecision 1ps;

	import hoc_pkg::*;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               status;
	} count_result_t;

	class pair_tally #(int SLOTS = 256, int KEY_BYTES = 4);

		localparam int KEY_LIMIT = (KEY_BYTES < 4) ? KEY_BYTES : 4;
		localparam bit [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
		localparam bit [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;

		bit                 used [SLOTS];
		logic [31:0]        slot_key [SLOTS];
		int unsigned        slot_len [SLOTS];
		logic [SCOPE_W-1:0] slot_scope [SLOTS];
		logic [COUNT_W-1:0] slot_count [SLOTS];
		count_result_t      owed [$];

		int unsigned errors;
		int unsigned n_items;
		int unsigned n_clears;
		int unsigned n_counts;
		int unsigned n_probed;
		int unsigned n_saturated;
		int unsigned n_full;

		function int unsigned pending();
			return owed.size();
		endfunction

		function void note_item(logic op, logic [31:0] key, logic [LEN_W-1:0] len,
				logic [SCOPE_W-1:0] sc);
			count_result_t r;
			int unsigned   n;
			int unsigned   b;
			int unsigned   p;
			int unsigned   slot;
			logic [31:0]   k;
			bit [63:0]     h;
			r = '0;
			n_items++;
			if (op == OP_CLEAR) begin
				n_clears++;
				foreach (used[i])
					used[i] = 1'b0;
			end else begin
				n_counts++;
				n = (len > KEY_LIMIT) ? KEY_LIMIT : len;
				k = (n >= 4) ? key : key & ((32'd1 << (8 * n)) - 32'd1);
				h = FNV_BASIS;
				for (b = 0; b < n; b++) begin
					h = h ^ {56'd0, k[8*b +: 8]};
					h = h * FNV_PRIME;
				end
				h = h ^ {48'd0, sc};
				h = h * FNV_PRIME;
				slot = int'(h & 64'(SLOTS - 1));
				r.status = 1'b1;
				for (p = 0; p < SLOTS; p++) begin
					if (!used[slot]) begin
						used[slot]       = 1'b1;
						slot_key[slot]   = k;
						slot_len[slot]   = n;
						slot_scope[slot] = sc;
						slot_count[slot] = 16'd1;
						r.count  = 16'd1;
						r.status = 1'b0;
						break;
					end
					if (slot_scope[slot] == sc && slot_len[slot] == n &&
							slot_key[slot] == k) begin
						if (slot_count[slot] != COUNT_MAX)
							slot_count[slot] = slot_count[slot] + 16'd1;
						else
							n_saturated++;
						r.count  = slot_count[slot];
						r.status = 1'b0;
						break;
					end
					slot = (slot + 1) % SLOTS;
				end
				if (r.status)
					n_full++;
				else if (p > 0)
					n_probed++;
			end
			owed.push_back(r);
		endfunction

		function void check_result(logic [COUNT_W-1:0] cnt, logic st);
			count_result_t want;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: result with nothing pending: count %0d status %0d",
					$time, cnt, st);
				return;
			end
			want = owed.pop_front();
			if (cnt !== want.count) begin
				errors++;
				$display("%0t: occurrence_count expected %0d got %0d", $time,
					want.count, cnt);
			end
			if (st !== want.status) begin
				errors++;
				$display("%0t: status expected %0d got %0d", $time, want.status, st);
			end
		endfunction

	endclass

	localparam int TABLE_SLOTS    = 256;
	localparam int KEY_BYTES      = 4;
	localparam int RANDOM_ITEMS   = 1500;
	localparam int WATCHDOG_LIMIT = 2000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               opcode;
	logic [31:0]        key_bytes;
	logic [LEN_W-1:0]   key_length;
	logic [SCOPE_W-1:0] scope;
	logic               done;
	logic [COUNT_W-1:0] occurrence_count;
	logic               status;

	pair_tally #(TABLE_SLOTS, KEY_BYTES) tally;

	int unsigned        burst_left;
	int unsigned        random_items;
	int unsigned        quiet_cycles;
	logic [31:0]        pool_key [64];
	logic [LEN_W-1:0]   pool_len [64];
	logic [SCOPE_W-1:0] pool_scope [64];
	logic [31:0]        fill_key [TABLE_SLOTS];
	logic [LEN_W-1:0]   fill_len [TABLE_SLOTS];

	hashed_occurrence_counter #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.KEY_BYTES(KEY_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.key_bytes(key_bytes),
		.key_length(key_length),
		.scope(scope),
		.done(done),
		.occurrence_count(occurrence_count),
		.status(status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1)
				tally.check_result(occurrence_count, status);
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no item or result for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("hashed_occurrence_counter regression: fail");
				$finish;
			end
		end
	end

	function automatic logic [31:0] rand_key();
		if ($urandom_range(0, 5) == 0)
			return $urandom_range(0, 255);
		return $urandom;
	endfunction

	function automatic logic [LEN_W-1:0] rand_length();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return LEN_W'($urandom_range(5, 7));
		return LEN_W'($urandom_range(1, 4));
	endfunction

	function automatic logic [SCOPE_W-1:0] rand_scope();
		case ($urandom_range(0, 3))
			0: return SCOPE_W'($urandom_range(0, 7));
			1: return 16'hFFFF - SCOPE_W'($urandom_range(0, 3));
			default: return SCOPE_W'($urandom);
		endcase
	endfunction

	// start stays high from one item to the next unless pacing or settle_results drops it
	task automatic send_item(input logic op, input logic [31:0] key,
			input logic [LEN_W-1:0] len, input logic [SCOPE_W-1:0] sc);
		start      <= 1'b1;
		opcode     <= op;
		key_bytes  <= key;
		key_length <= len;
		scope      <= sc;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		tally.note_item(op, key, len, sc);
		@(negedge clk);
	endtask

	task automatic paced_item(input logic op, input logic [31:0] key,
			input logic [LEN_W-1:0] len, input logic [SCOPE_W-1:0] sc);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12))
				@(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		send_item(op, key, len, sc);
		random_items++;
	endtask

	task automatic settle_results();
		start <= 1'b0;
		while (tally.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int unsigned      i;
		int unsigned      j;
		int unsigned      pick;
		int unsigned      pool_n;
		int unsigned      run_len;
		int unsigned      phase;
		int unsigned      fills;
		logic [31:0]      keep;
		logic [LEN_W-1:0] len;
		tally      = new();
		arst_n     = 1'b0;
		start      = 1'b0;
		opcode     = OP_COUNT;
		key_bytes  = '0;
		key_length = LEN_W'(1);
		scope      = '0;
		repeat (7)
			@(negedge clk);
		arst_n = 1'b1;

		send_item(OP_COUNT, 32'hFFFF_FFFF, 3'd4, 16'hFFFF);
		send_item(OP_COUNT, 32'hFFFF_FFFF, 3'd4, 16'hFFFF);
		send_item(OP_COUNT, 32'h0000_0000, 3'd1, 16'h0000);
		send_item(OP_COUNT, 32'h0000_0000, 3'd3, 16'h0000);
		send_item(OP_COUNT, 32'h1234_5678, 3'd0, 16'h0005);
		send_item(OP_COUNT, 32'h0000_0000, 3'd0, 16'h0005);
		send_item(OP_COUNT, 32'hA5A5_A5A5, 3'd7, 16'h0001);
		send_item(OP_COUNT, 32'hA5A5_A5A5, 3'd4, 16'h0001);
		send_item(OP_COUNT, 32'hA5A5_A5A5, 3'd5, 16'h0001);
		send_item(OP_COUNT, 32'hA5A5_A5A5, 3'd6, 16'h0001);
		send_item(OP_COUNT, 32'h0041_0042, 3'd4, 16'h0002);
		send_item(OP_COUNT, 32'h0041_0042, 3'd3, 16'h0002);
		send_item(OP_COUNT, 32'hDEAD_BE41, 3'd1, 16'h0007);
		send_item(OP_COUNT, 32'h0000_0041, 3'd1, 16'h0007);
		send_item(OP_COUNT, 32'h0000_0041, 3'd2, 16'h0007);
		send_item(OP_COUNT, 32'h8080_8080, 3'd4, 16'h8000);
		send_item(OP_COUNT, 32'h8080_8080, 3'd4, 16'h7FFF);
		send_item(OP_CLEAR, 32'hFFFF_FFFF, 3'd7, 16'hFFFF);
		send_item(OP_COUNT, 32'hFFFF_FFFF, 3'd4, 16'hFFFF);
		send_item(OP_COUNT, 32'h0000_0041, 3'd1, 16'h0007);
		send_item(OP_CLEAR, 32'h0000_0000, 3'd0, 16'h0000);
		send_item(OP_COUNT, 32'hFFFF_FFFF, 3'd4, 16'hFFFF);
		settle_results();

		phase = 0;
		fills = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (phase % 5 == 3 && fills < 2) begin
				// fill every slot with distinct scopes, then overflow and revisit
				fills++;
				paced_item(OP_CLEAR, $urandom, LEN_W'($urandom), SCOPE_W'($urandom));
				for (i = 0; i < TABLE_SLOTS + 24; i++) begin
					if (i < TABLE_SLOTS) begin
						fill_key[i] = rand_key();
						fill_len[i] = rand_length();
						paced_item(OP_COUNT, fill_key[i], fill_len[i], SCOPE_W'(i));
					end else if (i % 2 == 1) begin
						paced_item(OP_COUNT, rand_key(), rand_length(), SCOPE_W'(i));
					end else begin
						j = $urandom_range(0, TABLE_SLOTS - 1);
						paced_item(OP_COUNT, fill_key[j], fill_len[j], SCOPE_W'(j));
					end
				end
				settle_results();
			end else begin
				if ($urandom_range(0, 1) == 0)
					paced_item(OP_CLEAR, $urandom, LEN_W'($urandom), SCOPE_W'($urandom));
				pool_n = $urandom_range(1, 64);
				for (i = 0; i < pool_n; i++) begin
					pool_key[i]   = rand_key();
					pool_len[i]   = rand_length();
					pool_scope[i] = rand_scope();
				end
				run_len = $urandom_range(20, 120);
				for (i = 0; i < run_len; i++) begin
					pick = $urandom_range(0, 99);
					if (pick < 2) begin
						paced_item(OP_CLEAR, $urandom, LEN_W'($urandom), SCOPE_W'($urandom));
					end else if (pick < 87) begin
						// same pair, with the bytes past its length scrambled
						j    = $urandom_range(0, pool_n - 1);
						len  = pool_len[j];
						keep = (len >= 4) ? 32'hFFFF_FFFF : (32'd1 << (8 * len)) - 32'd1;
						paced_item(OP_COUNT, (pool_key[j] & keep) | ($urandom & ~keep), len,
							pool_scope[j]);
					end else begin
						paced_item(OP_COUNT, rand_key(), rand_length(), rand_scope());
					end
				end
				if ($urandom_range(0, 2) == 0)
					settle_results();
			end
			phase++;
		end
		settle_results();

		repeat (TABLE_SLOTS + 16)
			@(posedge clk);
		if (tally.pending() != 0) begin
			tally.errors++;
			$display("%0t: %0d results never arrived", $time, tally.pending());
		end
		$display("ran %0d items: %0d clears, %0d counts", tally.n_items, tally.n_clears,
			tally.n_counts);
		$display("%0d counts probed past the home slot, %0d hit the ceiling, %0d met a full table",
			tally.n_probed, tally.n_saturated, tally.n_full);
		if (tally.errors == 0)
			$display("hashed_occurrence_counter regression: pass");
		else
			$display("hashed_occurrence_counter regression: fail");
		$finish;
	end

endmodule
